// File: sv/rmq_pkg.sv
// rmq_pkg: shared types and constants for the rotation matrix to quaternion pipeline
// used by rmq_sqrt, rmq_div, rotation_matrix_to_quaternion_top, rmq_checker and tb; no dependencies
`default_nettype none
package rmq_pkg;

  localparam int FIELD_W = 18;
  localparam int DIFF_W  = 19;
  localparam int QUO_W   = 19;
  localparam int NLANES  = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [FIELD_W-1:0] FIELD_MAX = 18'sh1ffff;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = 18'sh20000;

  // sideband that rides along with the root through the pipeline
  typedef struct packed {
    logic [NLANES-1:0][DIFF_W-1:0] d;
    logic                          tpos;
    logic [1:0]                    dom;
    logic                          degen;
  } side_t;

endpackage
`default_nettype wire

// File: sv/rmq_sqrt.sv
// rmq_sqrt: pipelined integer square root, one root bit per register stage
// depends on rmq_pkg for the sideband type
`default_nettype none
module rmq_sqrt import rmq_pkg::*; #(
  parameter int NW = 38,
  parameter int SW = 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] n,
  input  wire side_t         in_side,
  output logic               out_valid,
  output logic [SW-1:0]      root,
  output side_t              out_side
);

  localparam int PW = 2 * SW;
  localparam int RW = SW + 3;

  logic          v  [0:SW];
  logic [PW-1:0] nr [0:SW];
  logic [RW-1:0] rm [0:SW];
  logic [SW-1:0] rt [0:SW];
  side_t         sd [0:SW];

  assign v[0]  = in_valid;
  assign nr[0] = PW'(n);
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign sd[0] = in_side;

  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [RW-1:0] remx;
    logic [RW-1:0] trial;
    logic          ge;

    assign remx  = {rm[g][RW-3:0], nr[g][PW-1:PW-2]};
    assign trial = RW'({rt[g], 2'b01});
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      nr[g+1] <= nr[g] << 2;
      rm[g+1] <= ge ? remx - trial : remx;
      rt[g+1] <= {rt[g][SW-2:0], ge};
      sd[g+1] <= sd[g];
    end
  end

  assign out_valid = v[SW];
  assign root      = rt[SW];
  assign out_side  = sd[SW];

endmodule
`default_nettype wire

// File: sv/rmq_div.sv
// rmq_div: three-lane pipelined restoring divider, rounded |d| / (2*root)
// depends on rmq_pkg; one quotient bit per stage after an overflow check stage
`default_nettype none
module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 19
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [SW-1:0]                in_root,
  input  wire side_t                        in_side,
  output logic                              out_valid,
  output logic [SW-1:0]                     out_root,
  output logic [NLANES-1:0][QUO_W-1:0]      quo,
  output side_t                             out_side
);

  localparam int QB  = QUO_W - 1;
  localparam int DW  = ((FIELD_W + FRAC_BITS > SW) ? FIELD_W + FRAC_BITS : SW) + 1;
  localparam int CW  = ((DW > SW + QUO_W + 1) ? DW : SW + QUO_W + 1) + 1;

  logic                          v   [0:QB];
  logic [NLANES-1:0][CW-1:0]     rem [0:QB];
  logic [NLANES-1:0][QB-1:0]     q   [0:QB];
  logic [NLANES-1:0]             ov  [0:QB];
  logic [CW-1:0]                 dv  [0:QB];
  logic [SW-1:0]                 sr  [0:QB];
  side_t                         sd  [0:QB];

  // prep stage: numerator with rounding term, doubled root, overflow past 18 bits
  logic [NLANES-1:0][CW-1:0] numer;
  logic [NLANES-1:0]         ovf;
  logic [CW-1:0]             dbl;

  assign dbl = CW'({in_root, 1'b0});

  for (genvar l = 0; l < NLANES; l++) begin : g_prep
    logic [DIFF_W-1:0] mag;
    assign mag      = in_side.d[l][DIFF_W-1] ? -in_side.d[l] : in_side.d[l];
    assign numer[l] = (CW'(mag[FIELD_W-1:0]) << FRAC_BITS) + CW'(in_root);
    assign ovf[l]   = numer[l] >= (dbl << QB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= numer;
    q[0]   <= '0;
    ov[0]  <= ovf;
    dv[0]  <= dbl;
    sr[0]  <= in_root;
    sd[0]  <= in_side;
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [CW-1:0]             sh;
    logic [NLANES-1:0]         ge;
    logic [NLANES-1:0][CW-1:0] rem_next;
    logic [NLANES-1:0][QB-1:0] q_next;

    assign sh = dv[g] << (QB - 1 - g);

    for (genvar l = 0; l < NLANES; l++) begin : g_lane
      assign ge[l]       = rem[g][l] >= sh;
      assign rem_next[l] = ge[l] ? rem[g][l] - sh : rem[g][l];
      assign q_next[l]   = {q[g][l][QB-2:0], ge[l]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      rem[g+1] <= rem_next;
      q[g+1]   <= q_next;
      ov[g+1]  <= ov[g];
      dv[g+1]  <= dv[g];
      sr[g+1]  <= sr[g];
      sd[g+1]  <= sd[g];
    end
  end

  for (genvar l = 0; l < NLANES; l++) begin : g_out
    assign quo[l] = ov[QB][l] ? {1'b1, {QB{1'b0}}} : {1'b0, q[QB][l]};
  end

  assign out_valid = v[QB];
  assign out_root  = sr[QB];
  assign out_side  = sd[QB];

endmodule
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion, fully pipelined: one matrix can be started in every
// cycle and busy never rises. Each transaction yields one result, strobed by done for
// one cycle; the depth is set by the one-bit-per-stage square root (SW = root width,
// 19 at FRAC_BITS = 16) and the 19-stage divider. Results cannot be held off by the
// receiver.
// depends on rmq_pkg, rmq_sqrt and rmq_div
`default_nettype none
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [FIELD_W-1:0] e00,
  input  wire logic signed [FIELD_W-1:0] e01,
  input  wire logic signed [FIELD_W-1:0] e02,
  input  wire logic signed [FIELD_W-1:0] e10,
  input  wire logic signed [FIELD_W-1:0] e11,
  input  wire logic signed [FIELD_W-1:0] e12,
  input  wire logic signed [FIELD_W-1:0] e20,
  input  wire logic signed [FIELD_W-1:0] e21,
  input  wire logic signed [FIELD_W-1:0] e22,
  output logic                           done,
  output logic signed [FIELD_W-1:0]      qx,
  output logic signed [FIELD_W-1:0]      qy,
  output logic signed [FIELD_W-1:0]      qz,
  output logic signed [FIELD_W-1:0]      qw,
  output logic                           degenerate
);

  localparam int AW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int NW = AW + FRAC_BITS;
  localparam int SW = (NW + 1) / 2;
  localparam int TW = FIELD_W + 2;
  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  assign busy = 1'b0;

  // stage 1: trace and dominant diagonal
  logic                      v1;
  logic signed [FIELD_W-1:0] m1 [0:8];
  logic signed [TW-1:0]      tr1;
  logic                      tpos1;
  logic [1:0]                dom1;

  logic signed [TW-1:0] tr;
  logic [1:0]           dom;

  always_comb begin
    tr  = TW'(e00) + TW'(e11) + TW'(e22);
    dom = AXIS_X;
    if (e11 > e00) dom = AXIS_Y;
    if (e22 > ((dom == AXIS_Y) ? e11 : e00)) dom = AXIS_Z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    m1[0] <= e00; m1[1] <= e01; m1[2] <= e02;
    m1[3] <= e10; m1[4] <= e11; m1[5] <= e12;
    m1[6] <= e20; m1[7] <= e21; m1[8] <= e22;
    tr1   <= tr;
    tpos1 <= tr > 0;
    dom1  <= dom;
  end

  // stage 2: root argument and the three differences
  logic signed [FIELD_W-1:0] mii, mjj, mkk;
  logic signed [AW-1:0]      arg;
  logic                      degen;
  side_t                     side_next;
  logic [NW-1:0]             n_next;

  function automatic logic [DIFF_W-1:0] dif(input logic signed [FIELD_W-1:0] a,
                                            input logic signed [FIELD_W-1:0] b);
    logic signed [DIFF_W-1:0] r;
    r = DIFF_W'(a) - DIFF_W'(b);
    return r;
  endfunction

  always_comb begin
    side_next = '0;
    unique case (dom1)
      AXIS_X: begin
        mii = m1[0]; mjj = m1[4]; mkk = m1[8];
        side_next.d[0] = dif(m1[1], m1[3]);
        side_next.d[1] = dif(m1[2], m1[6]);
        side_next.d[2] = dif(m1[5], m1[7]);
      end
      AXIS_Y: begin
        mii = m1[4]; mjj = m1[8]; mkk = m1[0];
        side_next.d[0] = dif(m1[5], m1[7]);
        side_next.d[1] = dif(m1[3], m1[1]);
        side_next.d[2] = dif(m1[6], m1[2]);
      end
      default: begin
        mii = m1[8]; mjj = m1[0]; mkk = m1[4];
        side_next.d[0] = dif(m1[6], m1[2]);
        side_next.d[1] = dif(m1[7], m1[5]);
        side_next.d[2] = dif(m1[1], m1[3]);
      end
    endcase
    if (tpos1) begin
      arg = AW'(tr1) + ONE;
      side_next.d[0] = dif(m1[5], m1[7]);
      side_next.d[1] = dif(m1[6], m1[2]);
      side_next.d[2] = dif(m1[1], m1[3]);
    end else begin
      arg = AW'(mii) - AW'(mjj) - AW'(mkk) + ONE;
    end
    degen           = !tpos1 && (arg <= 0);
    side_next.tpos  = tpos1;
    side_next.dom   = dom1;
    side_next.degen = degen;
    n_next          = degen ? '0 : (NW'($unsigned(arg)) << FRAC_BITS);
  end

  logic          v2;
  logic [NW-1:0] n2;
  side_t         side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    n2    <= n_next;
    side2 <= side_next;
  end

  logic          sq_valid;
  logic [SW-1:0] sq_root;
  side_t         sq_side;

  rmq_sqrt #(.NW(NW), .SW(SW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .n         (n2),
    .in_side   (side2),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  logic                         dv_valid;
  logic [SW-1:0]                dv_root;
  logic [NLANES-1:0][QUO_W-1:0] dv_quo;
  side_t                        dv_side;

  rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_root  (dv_root),
    .quo       (dv_quo),
    .out_side  (dv_side)
  );

  // output stage: sign, saturation and component placement
  function automatic logic [FIELD_W-1:0] sat_q(input logic [QUO_W-1:0] q, input logic neg);
    logic [FIELD_W-1:0] r;
    if (neg) begin
      r = (q > QUO_W'(131072)) ? FIELD_MIN : -q[FIELD_W-1:0];
    end else begin
      r = (q > QUO_W'(131071)) ? FIELD_MAX : q[FIELD_W-1:0];
    end
    return r;
  endfunction

  logic [SW-1:0]      half;
  logic [FIELD_W-1:0] qd, o0, o1, o2;
  logic [FIELD_W-1:0] qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    half = dv_root >> 1;
    qd   = (half > SW'(131071)) ? FIELD_MAX : half[FIELD_W-1:0];
    o0   = sat_q(dv_quo[0], dv_side.d[0][DIFF_W-1]);
    o1   = sat_q(dv_quo[1], dv_side.d[1][DIFF_W-1]);
    o2   = sat_q(dv_quo[2], dv_side.d[2][DIFF_W-1]);
    if (dv_side.degen) begin
      qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
    end else if (dv_side.tpos) begin
      qx_next = o0; qy_next = o1; qz_next = o2; qw_next = qd;
    end else begin
      unique case (dv_side.dom)
        AXIS_X: begin
          qx_next = qd; qy_next = o0; qz_next = o1; qw_next = o2;
        end
        AXIS_Y: begin
          qy_next = qd; qz_next = o0; qx_next = o1; qw_next = o2;
        end
        default: begin
          qz_next = qd; qx_next = o0; qy_next = o1; qw_next = o2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    qx         <= qx_next;
    qy         <= qy_next;
    qz         <= qz_next;
    qw         <= qw_next;
    degenerate <= dv_side.degen;
  end

endmodule
`default_nettype wire

// File: sv/rmq_checker.sv
// rmq_checker: port-level checks on the quaternion pipeline, bound to the top level
// depends on rmq_pkg and rotation_matrix_to_quaternion_top
`default_nettype none
module rmq_checker import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [FIELD_W-1:0] qx,
  input wire logic [FIELD_W-1:0] qy,
  input wire logic [FIELD_W-1:0] qz,
  input wire logic [FIELD_W-1:0] qw,
  input wire logic               degenerate
);

  localparam int AW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int NW  = AW + FRAC_BITS;
  localparam int SW  = (NW + 1) / 2;
  localparam int LAT = SW + 22;

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  // each transaction returns exactly after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing at expected latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LAT !done)
    else $error("result without transaction");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (qx == '0 && qy == '0 && qz == '0 && qw == '0))
    else $error("degenerate result not zero");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .qx         (qx),
  .qy         (qy),
  .qz         (qz),
  .qw         (qw),
  .degenerate (degenerate)
);
`default_nettype wire

// File: bench/tb.sv
// tb: self-checking bench for rotation_matrix_to_quaternion_top, directed table then random
// matrices, each result checked against a local integer model of the conversion or a known quaternion
// depends on rmq_pkg and the block's RTL
`timescale 1ns / 100ps
`default_nettype none
module tb import rmq_pkg::*;;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int N_RANDOM = 1130;

  typedef logic signed [FIELD_W-1:0] fld_t;
  typedef struct packed {
    fld_t qx, qy, qz, qw;
    logic degen;
  } quat_t;
  typedef struct {
    fld_t m [9];
    logic known;
    quat_t q;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  fld_t e [9];
  logic busy, done, degenerate;
  fld_t qx, qy, qz, qw;

  quat_t quat_q [$];
  int mismatches = 0;
  int timed_out = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .e00(e[0]), .e01(e[1]), .e02(e[2]), .e10(e[3]), .e11(e[4]), .e12(e[5]),
    .e20(e[6]), .e21(e[7]), .e22(e[8]),
    .done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw), .degenerate(degenerate)
  );

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // |d|/(2*root), round half away from zero
  function automatic longint div_root(longint d, longint s);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + s) / (2 * s);
    return (d < 0) ? -q : q;
  endfunction

  function automatic fld_t clip(longint v);
    if (v > 131071) return FIELD_MAX;
    if (v < -131072) return FIELD_MIN;
    return fld_t'(v);
  endfunction

  function automatic quat_t to_quat(fld_t mi [9]);
    longint m [3][3];
    longint q [4];
    longint tr, a, s;
    int i, j, k;
    quat_t r;
    for (int n = 0; n < 9; n++) m[n/3][n%3] = mi[n];
    for (int n = 0; n < 4; n++) q[n] = 0;
    r.degen = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = int_sqrt((tr + ONE) <<< FB);
      q[3] = s >>> 1;
      q[0] = div_root(m[1][2] - m[2][1], s);
      q[1] = div_root(m[2][0] - m[0][2], s);
      q[2] = div_root(m[0][1] - m[1][0], s);
    end else begin
      i = AXIS_X;
      if (m[1][1] > m[0][0]) i = AXIS_Y;
      if (m[2][2] > m[i][i]) i = AXIS_Z;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = m[i][i] - m[j][j] - m[k][k] + ONE;
      if (a <= 0) begin
        r.degen = 1'b1;
      end else begin
        s = int_sqrt(a <<< FB);
        q[i] = s >>> 1;
        q[j] = div_root(m[i][j] - m[j][i], s);
        q[k] = div_root(m[i][k] - m[k][i], s);
        q[3] = div_root(m[j][k] - m[k][j], s);
      end
    end
    r.qx = clip(q[0]); r.qy = clip(q[1]); r.qz = clip(q[2]); r.qw = clip(q[3]);
    return r;
  endfunction

  function automatic fld_t rnd_entry(int mode);
    case (mode)
      0: return fld_t'($urandom);
      1: return fld_t'($urandom_range(0, 2 * ONE) - ONE);
      2: return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
      default: return fld_t'($urandom_range(0, 64) - 32);
    endcase
  endfunction

  // random rotation-like matrix: sign-permutation plus small noise, or raw, unit-range, extreme or small fields
  function automatic row_t rnd_row();
    row_t r;
    int p, mode;
    r.known = 1'b0;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      p = $urandom_range(0, 5);
      for (int n = 0; n < 9; n++) r.m[n] = fld_t'($urandom_range(0, 8000) - 4000);
      for (int n = 0; n < 3; n++)
        r.m[n*3 + ((n + p) % 3 + (p >= 3 ? 3 - 2*n : 0) + 3) % 3] =
          $urandom_range(0, 1) ? fld_t'(ONE - 1 - $urandom_range(0, 20000))
                               : fld_t'(-ONE + $urandom_range(0, 20000));
    end else begin
      for (int n = 0; n < 9; n++) r.m[n] = rnd_entry(mode - 5 + ($urandom_range(0, 1)));
    end
    return r;
  endfunction

  task automatic send(row_t r);
    while ($urandom_range(0, 99) < 19 && !r.known) begin
      start <= 1'b0;
      @(posedge clk);
    end
    for (int n = 0; n < 9; n++) e[n] <= r.m[n];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    quat_q.push_back(r.known ? r.q : to_quat(r.m));
  endtask

  function automatic row_t mk(longint a0, longint a1, longint a2, longint a3, longint a4,
                              longint a5, longint a6, longint a7, longint a8);
    row_t r;
    r.m = '{fld_t'(a0), fld_t'(a1), fld_t'(a2), fld_t'(a3), fld_t'(a4),
            fld_t'(a5), fld_t'(a6), fld_t'(a7), fld_t'(a8)};
    r.known = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      quat_t got, want;
      got = '{qx, qy, qz, qw, degenerate};
      if (quat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = quat_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    row_t dir [$];
    row_t r;
    for (int t = 0; t < 9; t++) e[t] <= '0;
    // near identity: diagonal just under one
    r = mk(ONE-1, 0, 0, 0, ONE-1, 0, 0, 0, ONE-1);
    dir.push_back(r);
    // zero matrix: trace 0, dominant x, root 1, q = 0.5 on x
    r = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.known = 1'b1; r.q = '{18'sd32768, 18'sd0, 18'sd0, 18'sd0, 1'b0};
    dir.push_back(r);
    // one minimum and two maximum diagonal entries, positive trace
    r = mk(FIELD_MIN, 0, 0, 0, FIELD_MIN, 0, 0, 0, FIELD_MIN);
    r.m[4] = FIELD_MAX; r.m[8] = FIELD_MAX; r.m[0] = FIELD_MAX;
    r.m = '{FIELD_MIN, 0, 0, 0, FIELD_MAX, 0, 0, 0, FIELD_MAX};
    dir.push_back(r);
    r = mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
    r.m[0] = fld_t'(-ONE); r.m[4] = fld_t'(ONE-1); r.m[8] = fld_t'(ONE-1);
    dir.push_back(r);
    // trace zero with ties on the diagonal
    r = mk(-ONE, 7, 9, 3, -ONE, 5, 1, 2, -ONE);
    r.m[0] = fld_t'(-2*ONE); r.m[4] = fld_t'(ONE); r.m[8] = fld_t'(ONE); // trace 0
    dir.push_back(r);
    r = mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
           FIELD_MAX, FIELD_MAX, FIELD_MAX);
    dir.push_back(r);
    // all minimum: diagonal ties pick x
    r = mk(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
           FIELD_MIN, FIELD_MIN, FIELD_MIN);
    dir.push_back(r);
    // 180 degree turns about x, y, z and ties picking the lower axis
    dir.push_back(mk(ONE-1, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    dir.push_back(mk(-ONE, 0, 0, 0, ONE-1, 0, 0, 0, -ONE));
    dir.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE-1));
    dir.push_back(mk(0, 100, -200, 300, 0, -400, 500, -600, -5));
    dir.push_back(mk(-5, 1, 2, 3, -5, 4, 5, 6, -5));
    dir.push_back(mk(-9, 1, 2, 3, -5, 4, 5, 6, -5));
    // huge off-diagonal differences push components into saturation
    dir.push_back(mk(-ONE, FIELD_MAX, FIELD_MIN, FIELD_MIN, -ONE+1, FIELD_MAX,
                     FIELD_MAX, FIELD_MIN, -ONE));
    dir.push_back(mk(1, FIELD_MAX, FIELD_MIN, FIELD_MIN, 0, FIELD_MAX,
                     FIELD_MAX, FIELD_MIN, 0));
    dir.push_back(mk(0, 1, -1, -1, 0, 1, 1, -1, 1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir[n]) send(dir[n]);
    start <= 1'b0;
    // hold off until the pipeline drains
    while (quat_q.size() != 0) @(posedge clk);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= 300 && n < 500) begin
        r = rnd_row();
        for (int t = 0; t < 9; t++) e[t] <= r.m[t];
        start <= 1'b1;
        do @(posedge clk); while (busy);
        quat_q.push_back(to_quat(r.m));
      end else begin
        send(rnd_row());
      end
    end
    start <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && timed_out == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200000;
    timed_out = 1;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
